FILE: rtl/sact_pkg.sv
`timescale 1ns / 1ps
package sact_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_PURGE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ALIGN = 2'd1;
  localparam logic [1:0] ST_BYPASS = 2'd2;
  localparam logic [1:0] ST_IO    = 2'd3;

  localparam logic [1:0] FILL_NONE    = 2'd0;
  localparam logic [1:0] FILL_SHARED  = 2'd1;
  localparam logic [1:0] FILL_PRIVATE = 2'd2;

  localparam logic CFG_IO_BASE  = 1'b0;
  localparam logic CFG_IO_LIMIT = 1'b1;

  localparam int REG_BITS = 40;

  // Classified request handed from front to back.
  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  status;
    logic [43:0] addr;
  } req_t;

endpackage

FILE: rtl/sact_front.sv
`timescale 1ns / 1ps
module sact_front import sact_pkg::*; #(
  parameter int ADDR_BITS = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [39:0] address,
  input  logic [3:0]  access_length,
  input  logic        cached,
  input  logic [39:0] io_base,
  input  logic [39:0] io_limit,
  output logic        q_valid,
  output req_t        q_data,
  input  logic        q_take
);

  req_t        slot [2];
  logic [1:0]  cnt;
  logic        wptr, rptr;
  logic [ADDR_BITS-1:0] addr;
  logic [39:0] addr40;
  logic        in_io, bad_len, mis;
  req_t        req;
  logic        do_push, do_pop;

  assign addr   = ADDR_BITS'(address);
  assign addr40 = 40'(addr);
  assign in_io  = (io_base <= addr40) && (addr40 <= io_limit);
  assign bad_len = !(access_length == 4'd1 || access_length == 4'd2 ||
                     access_length == 4'd4 || access_length == 4'd8);
  assign mis = bad_len || ((addr40[3:0] & (access_length - 4'd1)) != 4'd0);

  always_comb begin
    req.op   = operation;
    req.addr = 44'(addr);
    if (operation <= OP_WRITE && (in_io || !cached)) begin
      req.status = ST_BYPASS;
    end else if (operation >= OP_FLUSH && in_io) begin
      req.status = ST_IO;
    end else if (operation <= OP_WRITE && mis) begin
      req.status = ST_ALIGN;
    end else begin
      req.status = ST_OK;
    end
  end

  assign full    = cnt[1];
  assign q_valid = cnt != 2'd0;
  assign q_data  = slot[rptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wptr] <= req;
    end
    if (rst) begin
      cnt <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop) rptr <= !rptr;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overflow");
  a_push: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> cnt == $past(cnt) + 2'd1)
    else $error("push lost");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 || cnt == 2'd2) |-> wptr == rptr)
    else $error("pointer mismatch");

endmodule

FILE: rtl/sact_back.sv
`timescale 1ns / 1ps
module sact_back import sact_pkg::*; #(
  parameter int WAYS = 8,
  parameter int SETS = 128,
  parameter int LINE_BYTES = 32,
  parameter int ADDR_BITS = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  req_t        q_data,
  output logic        q_take,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic        hit,
  output logic [2:0]  way,
  output logic [6:0]  set_index,
  output logic [4:0]  line_offset,
  output logic        writeback,
  output logic [34:0] writeback_line,
  output logic [1:0]  fill
);

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int IDX_BITS = $clog2(SETS);
  localparam int LVLS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TREE = (1 << LVLS) - 1;
  localparam int TAG_BITS = ADDR_BITS - OFF_BITS - IDX_BITS;
  localparam int LN_BITS = ADDR_BITS - OFF_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_READ = 4'b0010, S_EXEC = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t state;
  req_t   req;

  // Per-way directory memories, cleared by sweep after reset.
  logic [TAG_BITS+1:0] dir [WAYS][SETS];
  logic [TAG_BITS+1:0] rd [WAYS];
  logic [TREE-1:0]     plru [SETS];
  logic [TREE-1:0]     prd;
  logic [IDX_BITS-1:0] clr_idx;
  logic                clearing;

  logic [ADDR_BITS-1:0] addr;
  logic [IDX_BITS-1:0]  set_raw, set_w;
  logic [TAG_BITS-1:0]  tag;
  logic                 found;
  logic [LVLS-1:0]      fw, vw, aw;
  logic [TREE-1:0]      pnew;
  logic [TAG_BITS+1:0]  ent;

  assign addr    = req.addr[ADDR_BITS-1:0];
  assign set_raw = addr[OFF_BITS +: IDX_BITS];
  assign set_w   = (32'(set_raw) >= SETS) ? IDX_BITS'(32'(set_raw) - SETS) : set_raw;
  assign tag     = addr[ADDR_BITS-1 -: TAG_BITS];

  always_comb begin
    found = 1'b0;
    fw = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd[w][TAG_BITS+1] && rd[w][TAG_BITS-1:0] == tag) begin
        found = 1'b1;
        fw = LVLS'(w);
      end
    end
  end

  always_comb begin
    logic [LVLS-1:0] v;
    int node;
    v = '0;
    node = 0;
    for (int l = 0; l < LVLS; l++) begin
      v[LVLS-1-l] = !prd[node];
      node = 2 * node + 1 + int'(!prd[node]);
    end
    if (32'(v) >= WAYS) v[LVLS-1] = 1'b0;
    if (32'(v) >= WAYS) v = '0;
    vw = v;
  end

  assign aw = found ? fw : vw;

  always_comb begin
    int node;
    pnew = prd;
    node = 0;
    for (int l = 0; l < LVLS; l++) begin
      pnew[node] = aw[LVLS-1-l];
      node = 2 * node + 1 + int'(aw[LVLS-1-l]);
    end
  end

  assign ent = rd[aw];
  assign q_take = (state == S_IDLE) && q_valid && !clearing && empty;

  always_ff @(posedge clk) begin
    if (clearing) begin
      for (int w = 0; w < WAYS; w++) dir[w][clr_idx] <= '0;
      plru[clr_idx] <= '0;
    end else if (state == S_EXEC && req.status == ST_OK) begin
      if (req.op <= OP_WRITE) begin
        plru[set_w] <= pnew;
        if (found) begin
          if (req.op == OP_WRITE) dir[aw][set_w] <= {1'b1, 1'b1, ent[TAG_BITS-1:0]};
        end else begin
          dir[aw][set_w] <= {1'b1, req.op == OP_WRITE, tag};
        end
      end else if (found) begin
        if (req.op == OP_PURGE) dir[aw][set_w] <= '0;
        else dir[aw][set_w] <= {1'b1, 1'b0, ent[TAG_BITS-1:0]};
      end
    end
    if (state == S_READ) begin
      for (int w = 0; w < WAYS; w++) rd[w] <= dir[w][set_w];
      prd <= plru[set_w];
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) req <= q_data;
    if (state == S_EXEC) begin
      status <= req.status;
      set_index <= 7'(set_w);
      line_offset <= 5'(addr[OFF_BITS-1:0]);
      hit <= 1'b0;
      way <= '0;
      writeback <= 1'b0;
      writeback_line <= '0;
      fill <= FILL_NONE;
      if (req.status == ST_OK) begin
        if (req.op <= OP_WRITE) begin
          hit <= found;
          way <= 3'(aw);
          if (!found) begin
            fill <= (req.op == OP_WRITE) ? FILL_PRIVATE : FILL_SHARED;
            if (ent[TAG_BITS+1] && ent[TAG_BITS]) begin
              writeback <= 1'b1;
              writeback_line <= 35'(LN_BITS'({ent[TAG_BITS-1:0], set_w}));
            end
          end
        end else if (found) begin
          hit <= 1'b1;
          way <= 3'(fw);
          if (ent[TAG_BITS]) begin
            writeback <= 1'b1;
            writeback_line <= 35'(LN_BITS'({ent[TAG_BITS-1:0], set_w}));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      empty <= 1'b1;
      clearing <= 1'b1;
      clr_idx <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + IDX_BITS'(1);
        if (32'(clr_idx) == SETS - 1) clearing <= 1'b0;
      end
      if (pop && !empty) empty <= 1'b1;
      case (state)
        S_IDLE: if (q_take) state <= S_READ;
        S_READ: state <= S_EXEC;
        S_EXEC: state <= S_OUT;
        S_OUT: begin
          empty <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_take: assert property (@(posedge clk) disable iff (rst) q_take |-> !clearing)
    else $error("request taken during clear");
  a_out: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> !empty)
    else $error("result not presented");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    !empty && fill != FILL_NONE |-> !hit && status == ST_OK)
    else $error("fill on hit");

endmodule

FILE: rtl/set_assoc_cache_tag_controller_unit.sv
`timescale 1ns / 1ps
// Tag directory of a write-back set-associative cache with per-set tree PLRU.
// Requests enter through push/full with operation, address, access_length and
// cached; results leave through empty/pop with status, hit, way, set_index,
// line_offset, writeback, writeback_line and fill.
// Configuration (io_base index 0, io_limit index 1) is written through
// cfg_valid/cfg_ready with cfg_index and cfg_data; write only while idle.
// The front classifies each request (bypass, I/O, misalignment) into a
// two-entry queue; the back runs one request at a time through directory
// read, update and result stages.
// An accepted request passes through the read, execute and present states
// before empty drops. The back takes the next request only after the result
// is popped.
// Reset: after rst drops, a sweep clears the directory one set per cycle,
// while requests wait in the queue.
// A result that is not popped holds the back; the queue then fills and full
// rises.
module set_assoc_cache_tag_controller_unit import sact_pkg::*; #(
  parameter int WAYS = 8,
  parameter int SETS = 128,
  parameter int LINE_BYTES = 32,
  parameter int ADDR_BITS = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [39:0] address,
  input  logic [3:0]  access_length,
  input  logic        cached,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic        hit,
  output logic [2:0]  way,
  output logic [6:0]  set_index,
  output logic [4:0]  line_offset,
  output logic        writeback,
  output logic [34:0] writeback_line,
  output logic [1:0]  fill,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [39:0] cfg_data
);

  logic [REG_BITS-1:0] io_base, io_limit;
  logic q_valid, q_take;
  req_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      io_base <= '1;
      io_limit <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IO_BASE:  io_base <= cfg_data;
        CFG_IO_LIMIT: io_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  sact_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk, .rst, .push, .full, .operation, .address, .access_length, .cached,
    .io_base, .io_limit, .q_valid, .q_data, .q_take
  );

  sact_back #(.WAYS(WAYS), .SETS(SETS), .LINE_BYTES(LINE_BYTES),
              .ADDR_BITS(ADDR_BITS)) u_back (
    .clk, .rst, .q_valid, .q_data, .q_take, .empty, .pop, .status, .hit, .way,
    .set_index, .line_offset, .writeback, .writeback_line, .fill
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sact_pkg::*;

  localparam int NWAYS = 8;
  localparam int NSETS = 128;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [39:0] addr;
    logic [3:0]  len;
    logic        cached;
  } access_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [2:0]  way;
    logic [6:0]  set_index;
    logic [4:0]  line_offset;
    logic        writeback;
    logic [34:0] writeback_line;
    logic [1:0]  fill;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] operation = '0;
  logic [39:0] address = '0;
  logic [3:0] access_length = 4'd1;
  logic cached = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] status;
  logic hit;
  logic [2:0] way;
  logic [6:0] set_index;
  logic [4:0] line_offset;
  logic writeback;
  logic [34:0] writeback_line;
  logic [1:0] fill;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [39:0] cfg_data = '0;

  set_assoc_cache_tag_controller_unit DUT (.*);

  // Predictor state
  logic [39:0] io_base_q, io_limit_q;
  logic        dir_valid [NWAYS*NSETS];
  logic        dir_dirty [NWAYS*NSETS];
  logic [27:0] dir_tag   [NWAYS*NSETS];
  logic [6:0]  tree_bits [NSETS];

  access_t pending_q[$];
  lookup_t expected_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit rx_hold = 1'b0;
  bit took = 1'b0;

  function automatic logic [2:0] tree_victim(logic [6:0] s);
    int node;
    logic [2:0] w;
    logic go;
    node = 0;
    w = '0;
    for (int l = 0; l < 3; l++) begin
      go = !s[node];
      w = {w[1:0], go};
      node = 2 * node + 1 + go;
    end
    return w;
  endfunction

  function automatic logic [6:0] tree_touch(logic [6:0] s, logic [2:0] w);
    int node;
    node = 0;
    for (int l = 0; l < 3; l++) begin
      s[node] = w[2-l];
      node = 2 * node + 1 + w[2-l];
    end
    return s;
  endfunction

  function automatic lookup_t predict_lookup(access_t a);
    lookup_t r;
    logic [6:0] st;
    logic [27:0] tg;
    logic in_io, found, is_rw;
    logic [2:0] w;
    int e;
    r = '0;
    st = a.addr[11:5];
    tg = a.addr[39:12];
    r.set_index = st;
    r.line_offset = a.addr[4:0];
    in_io = (io_base_q <= a.addr) && (a.addr <= io_limit_q);
    is_rw = (a.op == OP_READ) || (a.op == OP_WRITE);
    found = 1'b0;
    w = '0;
    if (is_rw && (in_io || !a.cached)) r.status = ST_BYPASS;
    else if (!is_rw && in_io) r.status = ST_IO;
    else if (is_rw && (!(a.len inside {4'd1, 4'd2, 4'd4, 4'd8}) ||
             ((a.addr[3:0] & (a.len - 4'd1)) != 0))) r.status = ST_ALIGN;
    else begin
      r.status = ST_OK;
      for (int i = NWAYS - 1; i >= 0; i--) begin
        if (dir_valid[i*NSETS+st] && dir_tag[i*NSETS+st] == tg) begin
          found = 1'b1;
          w = i[2:0];
        end
      end
      if (is_rw) begin
        if (found) begin
          r.hit = 1'b1;
          tree_bits[st] = tree_touch(tree_bits[st], w);
          if (a.op == OP_WRITE) dir_dirty[w*NSETS+st] = 1'b1;
        end else begin
          w = tree_victim(tree_bits[st]);
          tree_bits[st] = tree_touch(tree_bits[st], w);
          e = w * NSETS + st;
          if (dir_valid[e] && dir_dirty[e]) begin
            r.writeback = 1'b1;
            r.writeback_line = {dir_tag[e], st};
          end
          dir_valid[e] = 1'b1;
          dir_tag[e] = tg;
          dir_dirty[e] = (a.op == OP_WRITE);
          r.fill = (a.op == OP_WRITE) ? FILL_PRIVATE : FILL_SHARED;
        end
        r.way = w;
      end else if (found) begin
        r.hit = 1'b1;
        r.way = w;
        e = w * NSETS + st;
        if (dir_dirty[e]) begin
          r.writeback = 1'b1;
          r.writeback_line = {dir_tag[e], st};
          dir_dirty[e] = 1'b0;
        end
        if (a.op == OP_PURGE) begin
          dir_valid[e] = 1'b0;
          dir_tag[e] = '0;
        end
      end
    end
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Driver: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && !took) begin
      // hold the request until it is accepted
    end else if (pending_q.size() == 0) begin
      push <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      push <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) gap_left = $urandom_range(0, 6);
      end
      burst_left--;
      push <= 1'b1;
      operation <= pending_q[0].op;
      address <= pending_q[0].addr;
      access_length <= pending_q[0].len;
      cached <= pending_q[0].cached;
    end
  end

  // Predict on accept and retire the request from the pending queue
  always @(posedge clk) begin
    took = !rst && push && !full;
    if (took) begin
      expected_q.push_back(predict_lookup(pending_q[0]));
      void'(pending_q.pop_front());
    end
  end

  // Receiver stall pattern
  always @(negedge clk) begin
    if (rst || rx_hold) pop <= 1'b0;
    else pop <= ($urandom_range(0, 9) < 7) || (cycles % 200 < 60);
  end

  // Monitor
  always @(posedge clk) begin
    lookup_t act, exp_r;
    if (!rst && pop && !empty) begin
      act = '{status, hit, way, set_index, line_offset, writeback, writeback_line, fill};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", act);
      end else begin
        exp_r = expected_q.pop_front();
        if (act !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, act);
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [39:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_IO_BASE) io_base_q = val;
    else io_limit_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Addresses mostly land on a few sets and tags so lines conflict and get evicted
  function automatic access_t rand_access();
    access_t a;
    logic [3:0] lens [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
    a.op = $urandom_range(0, 9) < 7 ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
    if ($urandom_range(0, 9) < 8) begin
      a.addr = {$urandom_range(0, 11) == 0 ? 28'($urandom) : 28'($urandom_range(0, 11)),
                7'($urandom_range(0, 3)), 5'($urandom)};
      a.len = lens[$urandom_range(0, 3)];
      if ($urandom_range(0, 9) != 0) a.addr[2:0] = a.addr[2:0] & ~(3'(a.len - 1));
    end else begin
      a.addr = {8'($urandom), 32'($urandom)};
      a.len = 4'($urandom);
    end
    a.cached = $urandom_range(0, 15) != 0;
    return a;
  endfunction

  initial begin
    io_base_q = '1;
    io_limit_q = '0;
    for (int i = 0; i < NWAYS*NSETS; i++) begin
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      dir_tag[i] = '0;
    end
    for (int i = 0; i < NSETS; i++) tree_bits[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: fill one set past its ways, dirty lines, flush, purge, extremes
    for (int i = 0; i < 10; i++)
      pending_q.push_back('{OP_WRITE, {28'(i), 7'd3, 5'd0}, 4'd8, 1'b1});
    pending_q.push_back('{OP_READ, {28'(9), 7'd3, 5'd4}, 4'd4, 1'b1});
    pending_q.push_back('{OP_FLUSH, {28'(9), 7'd3, 5'd0}, 4'd0, 1'b0});
    pending_q.push_back('{OP_PURGE, {28'(9), 7'd3, 5'd0}, 4'd15, 1'b0});
    pending_q.push_back('{OP_PURGE, {28'(9), 7'd3, 5'd0}, 4'd1, 1'b1});
    pending_q.push_back('{OP_READ, 40'hFF_FFFF_FFFF, 4'd1, 1'b1});
    pending_q.push_back('{OP_WRITE, 40'hFF_FFFF_FFF8, 4'd8, 1'b1});
    pending_q.push_back('{OP_READ, 40'h0, 4'd1, 1'b0});
    pending_q.push_back('{OP_READ, 40'h2, 4'd4, 1'b1});
    pending_q.push_back('{OP_WRITE, 40'h3, 4'd3, 1'b1});
    pending_q.push_back('{OP_READ, 40'h0, 4'd0, 1'b1});
    pending_q.push_back('{OP_FLUSH, 40'hFF_FFFF_FFF8, 4'd8, 1'b1});
    drain();

    // I/O range phases: narrow, everything, single address
    write_reg(CFG_IO_BASE, 40'h0);
    write_reg(CFG_IO_LIMIT, 40'h3_FFFF);
    pending_q.push_back('{OP_FLUSH, 40'h100, 4'd1, 1'b1});
    pending_q.push_back('{OP_READ, 40'h3_FFFF, 4'd1, 1'b1});
    pending_q.push_back('{OP_READ, 40'h4_0000, 4'd1, 1'b1});
    for (int i = 0; i < 100; i++) pending_q.push_back(rand_access());
    drain();
    write_reg(CFG_IO_LIMIT, 40'hFF_FFFF_FFFF);
    for (int i = 0; i < 20; i++) pending_q.push_back(rand_access());
    drain();
    write_reg(CFG_IO_BASE, 40'h1000);
    write_reg(CFG_IO_LIMIT, 40'h1000);
    pending_q.push_back('{OP_PURGE, 40'h1000, 4'd1, 1'b1});

    // Receiver holds off long so the queue fills
    rx_hold = 1'b1;
    for (int i = 0; i < 40; i++) pending_q.push_back(rand_access());
    repeat (300) @(posedge clk);
    rx_hold = 1'b0;
    drain();

    write_reg(CFG_IO_BASE, 40'hFF_FFFF_FFFF);
    write_reg(CFG_IO_LIMIT, 40'h0);
    for (int i = 0; i < 250; i++) pending_q.push_back(rand_access());
    drain();

    if (mismatches == 0 && expected_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
rtl/sact_pkg.sv
rtl/sact_front.sv
rtl/sact_back.sv
rtl/set_assoc_cache_tag_controller_unit.sv
dv/tb_top.sv
